>>> sv/srsw_pkg.sv
// Shared types and constants for the selective-repeat sender window unit.
// Holds the request and result payload structs, command and timer codes.
// No dependencies.
package srsw_pkg;

	localparam logic [1:0] CMD_NEW     = 2'd0;
	localparam logic [1:0] CMD_ACK     = 2'd1;
	localparam logic [1:0] CMD_TIMEOUT = 2'd2;

	localparam logic [1:0] TIMER_NONE    = 2'd0;
	localparam logic [1:0] TIMER_START   = 2'd1;
	localparam logic [1:0] TIMER_STOP    = 2'd2;
	localparam logic [1:0] TIMER_RESTART = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] ack_number;
		logic       ack_intact;
	} evt_t;

	typedef struct packed {
		logic       send_valid;
		logic [3:0] send_seq;
		logic       window_blocked;
		logic       ack_was_new;
		logic [1:0] timer_action;
	} res_t;

endpackage

>>> sv/srsw_stream_if.sv
// Valid/ready stream channel used for requests and results.
// Payload type is a parameter; depends on nothing else.
interface srsw_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/selective_repeat_sender_window_unit.sv
// Selective-repeat sender window unit: top level.
// An accepted request is held in the request register; its result goes to the result register.
// Throughput: one request per cycle while rsp is not stalled; window update and slide fit one pass
// between the request register and the result register.
// Reset: arst_n clears base, next sequence, in-flight count, acked flags
// and the valid bits of both registers. Depends on srsw_pkg, srsw_stream_if.
module selective_repeat_sender_window_unit import srsw_pkg::*; #(
	parameter int WINDOW    = 6,
	parameter int SEQ_SPACE = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	srsw_stream_if.sink   evt,
	srsw_stream_if.source rsp
);

	localparam int SEQ_W = $clog2(SEQ_SPACE);
	localparam int CNT_W = $clog2(WINDOW + 1);

	logic              req_valid_s1;
	evt_t              req_s1;
	logic              rsp_valid_q;
	res_t              rsp_q;
	logic [SEQ_W-1:0]  base_q;
	logic [SEQ_W-1:0]  next_seq_q;
	logic [CNT_W-1:0]  unacked_q;
	logic [WINDOW-1:0] acked_q;

	res_t              res_c;
	logic [SEQ_W-1:0]  base_c;
	logic [SEQ_W-1:0]  next_seq_c;
	logic [CNT_W-1:0]  unacked_c;
	logic [WINDOW-1:0] acked_c;
	logic [SEQ_W-1:0]  outstanding_c;
	logic              adv;
	logic              fire;

	srsw_step #(
		.WINDOW    (WINDOW),
		.SEQ_SPACE (SEQ_SPACE),
		.SEQ_W     (SEQ_W),
		.CNT_W     (CNT_W)
	) u_step (
		.req          (req_s1),
		.base         (base_q),
		.next_seq     (next_seq_q),
		.unacked      (unacked_q),
		.acked        (acked_q),
		.res          (res_c),
		.base_nxt     (base_c),
		.next_seq_nxt (next_seq_c),
		.unacked_nxt  (unacked_c),
		.acked_nxt    (acked_c),
		.outstanding  (outstanding_c)
	);

	assign adv       = !rsp_valid_q || rsp.ready;
	assign fire      = req_valid_s1 && adv;
	assign evt.ready = !req_valid_s1 || adv;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			req_valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid)
			req_s1 <= evt.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= req_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			rsp_q <= res_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			next_seq_q <= '0;
			unacked_q  <= '0;
			acked_q    <= '0;
		end else if (fire) begin
			base_q     <= base_c;
			next_seq_q <= next_seq_c;
			unacked_q  <= unacked_c;
			acked_q    <= acked_c;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W + 1)'(unacked_q) <= (CNT_W + 1)'(WINDOW))
		else $error("in-flight count exceeds window");

	a_count_vs_outstanding: assert property (@(posedge clk) disable iff (!arst_n)
		(SEQ_W + CNT_W)'(unacked_q) <= (SEQ_W + CNT_W)'(outstanding_c))
		else $error("in-flight count exceeds sent range");

	a_new_ack_drops: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_c.ack_was_new |=> unacked_q == $past(unacked_q) - CNT_W'(1))
		else $error("new ack did not drop in-flight count");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid_s1 && rsp_valid_q && !rsp.ready |=> $stable(base_q)
			&& $stable(next_seq_q) && $stable(acked_q))
		else $error("window state moved while stalled");

endmodule

>>> sv/srsw_step.sv
// Single-pass next-state and result logic for one request.
// Depends on srsw_pkg.
module srsw_step import srsw_pkg::*; #(
	parameter int WINDOW    = 6,
	parameter int SEQ_SPACE = 12,
	parameter int SEQ_W     = $clog2(SEQ_SPACE),
	parameter int CNT_W     = $clog2(WINDOW + 1)
) (
	input  evt_t              req,
	input  logic [SEQ_W-1:0]  base,
	input  logic [SEQ_W-1:0]  next_seq,
	input  logic [CNT_W-1:0]  unacked,
	input  logic [WINDOW-1:0] acked,
	output res_t              res,
	output logic [SEQ_W-1:0]  base_nxt,
	output logic [SEQ_W-1:0]  next_seq_nxt,
	output logic [CNT_W-1:0]  unacked_nxt,
	output logic [WINDOW-1:0] acked_nxt,
	output logic [SEQ_W-1:0]  outstanding
);

	localparam int OW = (SEQ_W > CNT_W) ? SEQ_W : CNT_W;
	localparam int AW = (SEQ_W + 1 > 4) ? SEQ_W + 1 : 4;

	function automatic logic [SEQ_W-1:0] seq_gap(input logic [SEQ_W-1:0] from,
			input logic [SEQ_W-1:0] to);
		logic [SEQ_W:0] sum;
		sum = {1'b0, to} + (SEQ_W + 1)'(SEQ_SPACE) - {1'b0, from};
		if (sum >= (SEQ_W + 1)'(SEQ_SPACE))
			sum = sum - (SEQ_W + 1)'(SEQ_SPACE);
		return sum[SEQ_W-1:0];
	endfunction

	logic [SEQ_W-1:0]  ack_seq;
	logic              ack_ok;
	logic [SEQ_W-1:0]  off;
	logic              room;
	logic              in_range;
	logic [WINDOW-1:0] hit;
	logic [WINDOW-1:0] clr;
	logic [WINDOW-1:0] marked;
	logic [WINDOW-1:0] run;
	logic [OW-1:0]     lim;
	logic [CNT_W-1:0]  n;
	logic [SEQ_W:0]    base_sum;
	logic [CNT_W-1:0]  unacked_dec;

	always_comb begin
		ack_seq     = SEQ_W'(AW'(req.ack_number));
		ack_ok      = req.ack_intact && (AW'(req.ack_number) < AW'(SEQ_SPACE));
		outstanding = seq_gap(base, next_seq);
		off         = seq_gap(base, ack_seq);
		room        = OW'(outstanding) < OW'(WINDOW);
		in_range    = (OW'(off) < OW'(outstanding)) && (OW'(off) < OW'(WINDOW));
		lim         = room ? OW'(outstanding) : OW'(WINDOW);
		for (int i = 0; i < WINDOW; i++) begin
			hit[i] = OW'(off) == OW'(i);
			clr[i] = OW'(outstanding) == OW'(i);
		end
		marked = acked | hit;
		for (int i = 0; i < WINDOW; i++)
			run[i] = marked[i] && (OW'(i) < lim);
		n = CNT_W'(WINDOW);
		for (int i = WINDOW - 1; i >= 0; i--) begin
			if (!run[i])
				n = CNT_W'(i);
		end
		base_sum = {1'b0, base} + {1'b0, SEQ_W'(n)};
		if (base_sum >= (SEQ_W + 1)'(SEQ_SPACE))
			base_sum = base_sum - (SEQ_W + 1)'(SEQ_SPACE);
		unacked_dec = (unacked != '0) ? unacked - CNT_W'(1) : unacked;
	end

	always_comb begin
		res          = '0;
		base_nxt     = base;
		next_seq_nxt = next_seq;
		unacked_nxt  = unacked;
		acked_nxt    = acked;
		case (req.command)
			CMD_NEW: begin
				if (room) begin
					res.send_valid = 1'b1;
					res.send_seq   = 4'(next_seq);
					acked_nxt      = acked & ~clr;
					unacked_nxt    = unacked + CNT_W'(1);
					if (outstanding == '0)
						res.timer_action = TIMER_START;
					next_seq_nxt = (next_seq == SEQ_W'(SEQ_SPACE - 1)) ? '0
						: next_seq + SEQ_W'(1);
				end else begin
					res.window_blocked = 1'b1;
				end
			end
			CMD_ACK: begin
				if (ack_ok && in_range) begin
					if ((hit & ~acked) != '0) begin
						res.ack_was_new = 1'b1;
						acked_nxt       = marked;
						unacked_nxt     = unacked_dec;
					end
					if (off == '0) begin
						acked_nxt        = marked >> n;
						base_nxt         = base_sum[SEQ_W-1:0];
						res.timer_action = (unacked_nxt != '0) ? TIMER_RESTART
							: TIMER_STOP;
					end
				end
			end
			CMD_TIMEOUT: begin
				if (outstanding != '0) begin
					res.send_valid   = 1'b1;
					res.send_seq     = 4'(base);
					res.timer_action = TIMER_START;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule
